@@ src/kmdc_pkg.sv @@
`timescale 1ns / 1ps
// Types, codes and helpers shared by the k-way merge cells and the core.
// No dependencies.
package kmdc_pkg;

    localparam int IDX_W  = 6;   // way index width, covers up to 64 ways
    localparam int REC_W  = 64;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_PUSH  = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;

    localparam logic [1:0] KIND_RECORD = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_CONFIG   = 2'd0;
    localparam logic [1:0] ERR_UNSORTED = 2'd1;
    localparam logic [1:0] ERR_FULL     = 2'd2;

    localparam logic [1:0] RULE_KEEP = 2'd0;
    localparam logic [1:0] RULE_LAST = 2'd1;
    localparam logic [1:0] RULE_OR   = 2'd2;

    localparam logic [1:0] REG_NUM_WAYS  = 2'd0;
    localparam logic [1:0] REG_REC_BYTES = 2'd1;
    localparam logic [1:0] REG_KEY_BYTES = 2'd2;
    localparam logic [1:0] REG_RULE      = 2'd3;

    localparam logic [3:0] COMBINE_BYTE_BACK = 4'd4;

    // Running minimum handed from cell to cell.
    typedef struct packed {
        logic             any;
        logic             blocked;
        logic [REC_W-1:0] rec;
        logic [IDX_W-1:0] idx;
    } chain_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic             clear;
        logic             push_en;
        logic             close_en;
        logic             pop_en;
        logic [IDX_W-1:0] sel;
        logic [3:0]       act_ways;
        logic [REC_W-1:0] rec;
    } cell_ctrl_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [REC_W-1:0] rec;
        logic [1:0]       err;
        logic [31:0]      dup;
        logic [31:0]      total;
    } result_t;

    function automatic logic [REC_W-1:0] bytes_mask(input logic [3:0] n);
        logic [REC_W-1:0] m;
        m = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (4'(b) < n)
            begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

@@ src/kmdc_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for commands in and results out.
// No dependencies.
interface kmdc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [2:0]  way;
    logic [63:0] record;

    modport source (output valid, cmd, way, record, input ready);
    modport sink   (input valid, cmd, way, record, output ready);
endinterface

interface kmdc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [63:0] out_record;
    logic [1:0]  error_code;
    logic [31:0] dup_total;
    logic [31:0] record_total;
    logic        last;

    modport source (output valid, kind, out_record, error_code, dup_total, record_total,
                    last, input ready);
    modport sink   (input valid, kind, out_record, error_code, dup_total, record_total,
                    last, output ready);
endinterface

@@ src/kway_merge_dedup_combine_core.sv @@
`timescale 1ns / 1ps
// K-way merge with duplicate combining: controller, result staging and APB
// registers over a chain of kmdc_cell. Depends on kmdc_pkg, kmdc_if, kmdc_cell.
//
// Usage:
//   in_ch carries commands (start, push record to a way, close a way); an
//   item is taken when valid and ready are both high. out_ch carries the
//   results: merged records, a done summary, or errors, each with running
//   duplicate and record totals; last marks the final result of an item.
//   The APB port holds num_ways, rec_bytes, key_bytes and merge_rule at
//   byte addresses 0, 4, 8, 12; write them only while the block is idle.
// Sequence:
//   One item at a time: accept state, decode state, then a settle phase
//   after every change to the way heads while the search ripples through
//   the cell chain, one cell per cycle. Each pop runs decide, take, settle;
//   a close may release several pops.
// Reset:
//   rst_n is asynchronous; all ways empty, idle, registers back to 8/8/8/0.
// Stalls:
//   One result is staged internally so that last can be set; it moves to the
//   output register only when that is free. A stalled receiver holds the
//   controller; the next item is taken once only the final result is left,
//   waiting in the output register.
module kway_merge_dedup_combine_core #(
    parameter int WAYS         = 8,
    parameter int RECORD_BYTES = 8,
    parameter int COUNT_BITS   = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    kmdc_in_if.sink            in_ch,
    kmdc_out_if.source         out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import kmdc_pkg::*;

    localparam int SET_W = $clog2(WAYS + 1);
    localparam logic [SET_W-1:0] SETTLE_LEN = SET_W'(WAYS);

    localparam logic [2:0] S_CMD    = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_SETTLE = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_TAKE   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    // ---- configuration registers ----
    logic [3:0] num_ways_reg, rec_bytes_reg, key_bytes_reg;
    logic [1:0] rule_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_ways_reg  <= 4'd8;
            rec_bytes_reg <= 4'd8;
            key_bytes_reg <= 4'd8;
            rule_reg      <= RULE_KEEP;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_NUM_WAYS:  num_ways_reg  <= pwdata[3:0];
                REG_REC_BYTES: rec_bytes_reg <= pwdata[3:0];
                REG_KEY_BYTES: key_bytes_reg <= pwdata[3:0];
                REG_RULE:      rule_reg      <= pwdata[1:0];
                default:       num_ways_reg  <= num_ways_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_NUM_WAYS:  prdata = {28'd0, num_ways_reg};
            REG_REC_BYTES: prdata = {28'd0, rec_bytes_reg};
            REG_KEY_BYTES: prdata = {28'd0, key_bytes_reg};
            REG_RULE:      prdata = {30'd0, rule_reg};
            default:       prdata = '0;
        endcase
    end

    // ---- cell chain ----
    cell_ctrl_t ctrl;
    chain_t     chain_w [WAYS+1];
    logic [WAYS-1:0] valid_w, closed_w, popped_w;
    logic [63:0]     last_w [WAYS];

    assign chain_w[0] = '0;

    for (genvar i = 0; i < WAYS; i++)
    begin : g_cell
        kmdc_cell #(.IDX(i)) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .chain_in    (chain_w[i]),
            .chain_out   (chain_w[i+1]),
            .head_valid  (valid_w[i]),
            .closed      (closed_w[i]),
            .popped_once (popped_w[i]),
            .last_popped (last_w[i])
        );
    end

    chain_t search;
    assign search = chain_w[WAYS];

    // ---- control state ----
    logic [2:0]            state_reg, state_next;
    logic [1:0]            cmd_reg;
    logic [2:0]            way_reg;
    logic [63:0]           rec_in_reg;
    logic                  run_reg, run_next;
    logic [3:0]            act_ways_reg, act_rec_reg, act_key_reg;
    logic [3:0]            act_ways_next, act_rec_next, act_key_next;
    logic [1:0]            act_rule_reg, act_rule_next;
    logic [63:0]           pend_rec_reg, pend_rec_next;
    logic                  pend_v_reg, pend_v_next;
    logic [COUNT_BITS-1:0] dup_cnt_reg, dup_cnt_next;
    logic [COUNT_BITS-1:0] emit_cnt_reg, emit_cnt_next;
    logic [SET_W-1:0]      settle_reg, settle_next;
    logic [63:0]           take_rec_reg, take_rec_next;

    // staged result and output register
    result_t hold_reg;
    logic    hold_v_reg;
    result_t out_reg;
    logic    out_last_reg;
    logic    out_valid_reg;
    logic    slot_free, put_ok, put_en, fin_en;
    result_t put_res;

    assign slot_free = !out_valid_reg || out_ch.ready;
    assign put_ok    = !hold_v_reg || slot_free;

    function automatic logic [31:0] sat32(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS+31:0] wide;
        wide = {32'd0, v};
        if (wide > (COUNT_BITS + 32)'(32'hFFFF_FFFF))
        begin
            return 32'hFFFF_FFFF;
        end
        return wide[31:0];
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // selected way status
    logic        sel_valid, sel_closed, sel_popped;
    logic [63:0] sel_last;
    logic        way_ok;
    logic [63:0] push_rec;

    always_comb
    begin
        sel_valid  = 1'b0;
        sel_closed = 1'b0;
        sel_popped = 1'b0;
        sel_last   = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (32'(way_reg) == i)
            begin
                sel_valid  = valid_w[i];
                sel_closed = closed_w[i];
                sel_popped = popped_w[i];
                sel_last   = last_w[i];
            end
        end
    end

    assign way_ok   = {1'b0, way_reg} < act_ways_reg;
    assign push_rec = rec_in_reg & bytes_mask(act_rec_reg);

    logic bad_cfg;
    assign bad_cfg = rec_bytes_reg == 4'd0
                  || 32'(rec_bytes_reg) > RECORD_BYTES
                  || key_bytes_reg > rec_bytes_reg
                  || 32'(num_ways_reg) > WAYS
                  || (rule_reg[1] && rec_bytes_reg < COMBINE_BYTE_BACK);

    // duplicate test and combining
    logic [63:0] key_mask;
    logic        is_dup;
    logic [7:0]  cb, rb, nb;
    logic [23:0] ct, rt;
    logic [63:0] combined;

    assign key_mask = bytes_mask(act_rec_reg) & ~bytes_mask(act_rec_reg - act_key_reg);
    assign is_dup   = ((pend_rec_reg ^ take_rec_reg) & key_mask) == '0;
    assign cb = pend_rec_reg[31:24];
    assign rb = take_rec_reg[31:24];
    assign ct = pend_rec_reg[23:0];
    assign rt = take_rec_reg[23:0];
    assign nb = (act_rule_reg == RULE_OR) ? (cb | rb) : ((rb > cb) ? rb : cb);
    assign combined = {pend_rec_reg[63:32], nb, (rt < ct) ? rt : ct};

    always_comb
    begin
        state_next    = state_reg;
        run_next      = run_reg;
        act_ways_next = act_ways_reg;
        act_rec_next  = act_rec_reg;
        act_key_next  = act_key_reg;
        act_rule_next = act_rule_reg;
        pend_rec_next = pend_rec_reg;
        pend_v_next   = pend_v_reg;
        dup_cnt_next  = dup_cnt_reg;
        emit_cnt_next = emit_cnt_reg;
        settle_next   = settle_reg;
        take_rec_next = take_rec_reg;
        put_en        = 1'b0;
        fin_en        = 1'b0;
        put_res       = '0;
        ctrl          = '0;
        ctrl.act_ways = act_ways_reg;
        ctrl.rec      = push_rec;
        ctrl.sel      = IDX_W'(way_reg);

        case (state_reg)
            S_CMD:
            begin
                if (in_ch.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FIN;
                case (cmd_reg)
                    CMD_START:
                    begin
                        if (bad_cfg)
                        begin
                            run_next      = 1'b0;
                            put_en        = 1'b1;
                            put_res.kind  = KIND_ERROR;
                            put_res.err   = ERR_CONFIG;
                            put_res.dup   = sat32(dup_cnt_reg);
                            put_res.total = sat32(emit_cnt_reg);
                        end
                        else
                        begin
                            act_ways_next = num_ways_reg;
                            act_rec_next  = rec_bytes_reg;
                            act_key_next  = key_bytes_reg;
                            act_rule_next = rule_reg;
                            ctrl.clear    = 1'b1;
                            pend_v_next   = 1'b0;
                            pend_rec_next = '0;
                            dup_cnt_next  = '0;
                            emit_cnt_next = '0;
                            run_next      = 1'b1;
                            settle_next   = SETTLE_LEN;
                            state_next    = S_SETTLE;
                        end
                    end
                    CMD_PUSH:
                    begin
                        if (!run_reg || !way_ok || sel_closed || sel_valid)
                        begin
                            put_en        = 1'b1;
                            put_res.kind  = KIND_ERROR;
                            put_res.err   = ERR_FULL;
                            put_res.dup   = sat32(dup_cnt_reg);
                            put_res.total = sat32(emit_cnt_reg);
                        end
                        else if (sel_popped && sel_last > push_rec)
                        begin
                            run_next      = 1'b0;
                            put_en        = 1'b1;
                            put_res.kind  = KIND_ERROR;
                            put_res.err   = ERR_UNSORTED;
                            put_res.dup   = sat32(dup_cnt_reg);
                            put_res.total = sat32(emit_cnt_reg);
                        end
                        else
                        begin
                            ctrl.push_en = 1'b1;
                            settle_next  = SETTLE_LEN;
                            state_next   = S_SETTLE;
                        end
                    end
                    CMD_CLOSE:
                    begin
                        if (run_reg)
                        begin
                            ctrl.close_en = way_ok;
                            settle_next   = SETTLE_LEN;
                            state_next    = S_SETTLE;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_SETTLE:
            begin
                // let the chain ripple through every cell
                if (settle_reg == '0)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    settle_next = settle_reg - 1'b1;
                end
            end
            S_DECIDE:
            begin
                if (search.blocked)
                begin
                    state_next = S_FIN;
                end
                else if (search.any)
                begin
                    ctrl.pop_en   = 1'b1;
                    ctrl.sel      = search.idx;
                    take_rec_next = search.rec;
                    state_next    = S_TAKE;
                end
                else if (!pend_v_reg)
                begin
                    state_next = S_DONE;
                end
                else if (put_ok)
                begin
                    emit_cnt_next = sat_inc(emit_cnt_reg);
                    pend_v_next   = 1'b0;
                    put_en        = 1'b1;
                    put_res.kind  = KIND_RECORD;
                    put_res.rec   = pend_rec_reg & bytes_mask(act_rec_reg);
                    put_res.dup   = sat32(dup_cnt_reg);
                    put_res.total = sat32(emit_cnt_next);
                    state_next    = S_DONE;
                end
            end
            S_TAKE:
            begin
                if (pend_v_reg && is_dup)
                begin
                    if (act_rule_reg == RULE_KEEP)
                    begin
                        if (put_ok)
                        begin
                            dup_cnt_next  = sat_inc(dup_cnt_reg);
                            emit_cnt_next = sat_inc(emit_cnt_reg);
                            put_en        = 1'b1;
                            put_res.kind  = KIND_RECORD;
                            put_res.rec   = pend_rec_reg & bytes_mask(act_rec_reg);
                            put_res.dup   = sat32(dup_cnt_next);
                            put_res.total = sat32(emit_cnt_next);
                            pend_rec_next = take_rec_reg;
                            settle_next   = SETTLE_LEN;
                            state_next    = S_SETTLE;
                        end
                    end
                    else
                    begin
                        dup_cnt_next  = sat_inc(dup_cnt_reg);
                        pend_rec_next = (act_rule_reg == RULE_LAST) ? take_rec_reg : combined;
                        settle_next   = SETTLE_LEN;
                        state_next    = S_SETTLE;
                    end
                end
                else if (pend_v_reg)
                begin
                    if (put_ok)
                    begin
                        emit_cnt_next = sat_inc(emit_cnt_reg);
                        put_en        = 1'b1;
                        put_res.kind  = KIND_RECORD;
                        put_res.rec   = pend_rec_reg & bytes_mask(act_rec_reg);
                        put_res.dup   = sat32(dup_cnt_reg);
                        put_res.total = sat32(emit_cnt_next);
                        pend_rec_next = take_rec_reg;
                        settle_next   = SETTLE_LEN;
                        state_next    = S_SETTLE;
                    end
                end
                else
                begin
                    pend_rec_next = take_rec_reg;
                    pend_v_next   = 1'b1;
                    settle_next   = SETTLE_LEN;
                    state_next    = S_SETTLE;
                end
            end
            S_DONE:
            begin
                if (put_ok)
                begin
                    run_next      = 1'b0;
                    put_en        = 1'b1;
                    put_res.kind  = KIND_DONE;
                    put_res.dup   = sat32(dup_cnt_reg);
                    put_res.total = sat32(emit_cnt_reg);
                    state_next    = S_FIN;
                end
            end
            S_FIN:
            begin
                // flush the staged result with last set
                if (put_ok)
                begin
                    fin_en     = 1'b1;
                    state_next = S_CMD;
                end
            end
            default:
            begin
                state_next = S_CMD;
            end
        endcase
    end

    assign in_ch.ready = (state_reg == S_CMD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CMD;
            run_reg       <= 1'b0;
            act_ways_reg  <= (WAYS < 8) ? 4'(WAYS) : 4'd8;
            act_rec_reg   <= 4'(RECORD_BYTES);
            act_key_reg   <= 4'(RECORD_BYTES);
            act_rule_reg  <= RULE_KEEP;
            pend_rec_reg  <= '0;
            pend_v_reg    <= 1'b0;
            dup_cnt_reg   <= '0;
            emit_cnt_reg  <= '0;
            settle_reg    <= '0;
            hold_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            run_reg      <= run_next;
            act_ways_reg <= act_ways_next;
            act_rec_reg  <= act_rec_next;
            act_key_reg  <= act_key_next;
            act_rule_reg <= act_rule_next;
            pend_rec_reg <= pend_rec_next;
            pend_v_reg   <= pend_v_next;
            dup_cnt_reg  <= dup_cnt_next;
            emit_cnt_reg <= emit_cnt_next;
            settle_reg   <= settle_next;
            if ((put_en || fin_en) && hold_v_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (put_en)
            begin
                hold_v_reg <= 1'b1;
            end
            else if (fin_en)
            begin
                hold_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        take_rec_reg <= take_rec_next;
        if (in_ch.valid && in_ch.ready)
        begin
            cmd_reg    <= in_ch.cmd;
            way_reg    <= in_ch.way;
            rec_in_reg <= in_ch.record;
        end
        if (put_en)
        begin
            hold_reg <= put_res;
        end
        if ((put_en || fin_en) && hold_v_reg)
        begin
            out_reg      <= hold_reg;
            out_last_reg <= fin_en;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.kind         = out_reg.kind;
    assign out_ch.out_record   = out_reg.rec;
    assign out_ch.error_code   = out_reg.err;
    assign out_ch.dup_total    = out_reg.dup;
    assign out_ch.record_total = out_reg.total;
    assign out_ch.last         = out_last_reg;

endmodule

@@ src/kmdc_cell.sv @@
`timescale 1ns / 1ps
// One way of the merge: head record, flags, last popped record, and one
// registered step of the minimum search chain. Depends on kmdc_pkg.
module kmdc_cell #(
    parameter int IDX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  kmdc_pkg::cell_ctrl_t ctrl,
    input  kmdc_pkg::chain_t    chain_in,
    output kmdc_pkg::chain_t    chain_out,
    output logic                head_valid,
    output logic                closed,
    output logic                popped_once,
    output logic [63:0]         last_popped
);
    import kmdc_pkg::*;

    logic [REC_W-1:0] head_reg;
    logic [REC_W-1:0] last_reg;
    logic             valid_reg;
    logic             closed_reg;
    logic             popped_reg;
    chain_t           chain_reg;
    chain_t           chain_next;
    logic             active;
    logic             hit;

    assign active = 32'(IDX) < 32'(ctrl.act_ways);
    assign hit    = ctrl.sel == IDX_W'(IDX);

    always_comb
    begin
        chain_next         = chain_in;
        chain_next.blocked = chain_in.blocked | (active & ~valid_reg & ~closed_reg);
        // strict less: lower way keeps ties
        if (active && valid_reg && (!chain_in.any || head_reg < chain_in.rec))
        begin
            chain_next.any = 1'b1;
            chain_next.rec = head_reg;
            chain_next.idx = IDX_W'(IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            closed_reg <= 1'b0;
            popped_reg <= 1'b0;
            chain_reg  <= '0;
        end
        else
        begin
            chain_reg <= chain_next;
            if (ctrl.clear)
            begin
                valid_reg  <= 1'b0;
                closed_reg <= 1'b0;
                popped_reg <= 1'b0;
            end
            else if (hit)
            begin
                if (ctrl.push_en)
                begin
                    valid_reg <= 1'b1;
                end
                if (ctrl.close_en)
                begin
                    closed_reg <= 1'b1;
                end
                if (ctrl.pop_en)
                begin
                    valid_reg  <= 1'b0;
                    popped_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit && ctrl.push_en)
        begin
            head_reg <= ctrl.rec;
        end
        if (hit && ctrl.pop_en)
        begin
            last_reg <= head_reg;
        end
    end

    assign chain_out   = chain_reg;
    assign head_valid  = valid_reg;
    assign closed      = closed_reg;
    assign popped_once = popped_reg;
    assign last_popped = last_reg;

endmodule

@@ src/kmdc_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks on the merge core's result channel, bound to the core.
// Depends on kmdc_pkg and kway_merge_dedup_combine_core.
module kmdc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        o_valid,
    input logic        o_ready,
    input logic [1:0]  o_kind,
    input logic [63:0] o_record,
    input logic [1:0]  o_error
);
    import kmdc_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid && !o_ready |=> o_valid)
        else $error("result dropped while stalled");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid |-> (o_kind == KIND_RECORD || o_kind == KIND_DONE || o_kind == KIND_ERROR))
        else $error("bad result kind");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid && o_kind != KIND_ERROR |-> o_error == ERR_CONFIG)
        else $error("error code on non-error item");

    a_rec_zero: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid && o_kind != KIND_RECORD |-> o_record == '0)
        else $error("record on non-record item");

endmodule

bind kway_merge_dedup_combine_core kmdc_checker u_kmdc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .o_valid  (out_ch.valid),
    .o_ready  (out_ch.ready),
    .o_kind   (out_ch.kind),
    .o_record (out_ch.out_record),
    .o_error  (out_ch.error_code)
);
